// File: rtl/core/brf_pkg.sv
// Shared types, constants and helpers for the bracketed root finder.
// Used by brf_ctrl, brf_dp and bracketed_root_finder_unit.
`default_nettype none
package brf_pkg;

  localparam int VALUE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int TOL_WIDTH     = 31;
  localparam int SPAN_WIDTH    = VALUE_WIDTH + 1;
  localparam int MUL_WIDTH     = SPAN_WIDTH;
  localparam int PROD_WIDTH    = 64;
  localparam int REM_WIDTH     = SPAN_WIDTH + 1;
  localparam int DIV_CNT_W     = 6;
  localparam int QCAP_BITS     = 40;
  localparam int Q_WIDTH       = QCAP_BITS + 1;
  localparam int C_WIDTH       = Q_WIDTH + 2;
  localparam int IN_TDATA_W    = 5 * VALUE_WIDTH;
  localparam int OUT_TDATA_W   = 40;
  localparam int CFG_IDX_W     = 1;

  localparam logic [Q_WIDTH-1:0] QCAP = Q_WIDTH'(1) << QCAP_BITS;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PROBE = 1'b1;

  localparam logic METHOD_BISECT   = 1'b0;
  localparam logic METHOD_FALSEPOS = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_METHOD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL    = 1'd1;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_NO_SIGN = 2'd1;
  localparam logic [1:0] ST_NO_CONV = 2'd2;
  localparam logic [1:0] ST_IDLE    = 2'd3;

  typedef enum logic [2:0] {
    DP_NOP, DP_CAPTURE, DP_UPDATE, DP_MUL_TOL, DP_MUL_NUM, DP_DIV_INIT, DP_DIV_STEP,
    DP_RESULT
  } dp_op_t;

  typedef enum logic [3:0] {
    RES_PROBE_MID, RES_PROBE_FP, RES_DONE_LOW, RES_DONE_HIGH, RES_DONE_LAST,
    RES_DONE_MID, RES_NO_SIGN, RES_NO_CONV, RES_IDLE
  } res_sel_t;

  typedef struct packed {
    dp_op_t   op;
    res_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_start;
    logic searching;
    logic method;
    logic low_zero;
    logic high_zero;
    logic same_sign;
    logic probe_zero;
    logic low_match;
    logic high_match;
    logic keep;
    logic low_small;
    logic high_small;
    logic div_last;
    logic out_free;
  } dp_stat_t;

  // same sign class: both zero, both negative or both positive
  function automatic logic sgn_eq(input logic signed [VALUE_WIDTH-1:0] a,
                                  input logic signed [VALUE_WIDTH-1:0] b);
    logic az, bz;
    az = (a == '0);
    bz = (b == '0);
    sgn_eq = (az && bz) || (a[VALUE_WIDTH-1] && b[VALUE_WIDTH-1]) ||
             (!az && !bz && !a[VALUE_WIDTH-1] && !b[VALUE_WIDTH-1]);
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] mag(input logic signed [VALUE_WIDTH-1:0] v);
    mag = v[VALUE_WIDTH-1] ? VALUE_WIDTH'(-v) : VALUE_WIDTH'(v);
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/brf_ctrl.sv
// Sequencer for the bracketed root finder: walks one item through update,
// stop tests, false-position multiply and divide, then result. Uses brf_pkg.
`default_nettype none
module brf_ctrl (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  input  brf_pkg::dp_stat_t stat,
  output brf_pkg::dp_cmd_t  cmd
);
  import brf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_MUL, S_CHK, S_MULN, S_DIVI, S_DIV, S_EMIT
  } state_t;

  state_t   state;
  res_sel_t sel;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd.sel = sel;
    case (state)
      S_IDLE:  cmd.op = s_tvalid ? DP_CAPTURE : DP_NOP;
      S_UPD:   cmd.op = DP_UPDATE;
      S_MUL:   cmd.op = DP_MUL_TOL;
      S_MULN:  cmd.op = DP_MUL_NUM;
      S_DIVI:  cmd.op = DP_DIV_INIT;
      S_DIV:   cmd.op = DP_DIV_STEP;
      S_EMIT:  cmd.op = stat.out_free ? DP_RESULT : DP_NOP;
      default: cmd.op = DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= RES_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_UPD;
        end
        S_UPD: begin
          if (stat.is_start) begin
            if (stat.method == METHOD_BISECT) begin
              if (stat.low_zero) begin
                state <= S_EMIT;
                sel   <= RES_DONE_LOW;
              end else if (stat.high_zero) begin
                state <= S_EMIT;
                sel   <= RES_DONE_HIGH;
              end else if (stat.same_sign) begin
                state <= S_EMIT;
                sel   <= RES_NO_SIGN;
              end else begin
                state <= S_MUL;
              end
            end else begin
              if (stat.same_sign) begin
                state <= S_EMIT;
                sel   <= RES_NO_SIGN;
              end else begin
                state <= S_MUL;
              end
            end
          end else if (!stat.searching) begin
            state <= S_EMIT;
            sel   <= RES_IDLE;
          end else if (stat.method == METHOD_BISECT) begin
            if (!(stat.low_match || stat.high_match)) begin
              state <= S_EMIT;
              sel   <= RES_DONE_LAST;
            end else begin
              state <= S_MUL;
            end
          end else begin
            if (stat.probe_zero) begin
              state <= S_EMIT;
              sel   <= RES_DONE_LAST;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_CHK;
        S_CHK: begin
          if (stat.method == METHOD_BISECT) begin
            state <= S_EMIT;
            if (stat.keep)          sel <= RES_PROBE_MID;
            else if (stat.is_start) sel <= RES_DONE_MID;
            else                    sel <= RES_DONE_LAST;
          end else begin
            if (!stat.keep) begin
              state <= S_EMIT;
              sel   <= RES_NO_CONV;
            end else if (stat.low_small) begin
              state <= S_EMIT;
              sel   <= RES_DONE_LOW;
            end else if (stat.high_small) begin
              state <= S_EMIT;
              sel   <= RES_DONE_HIGH;
            end else begin
              state <= S_MULN;
            end
          end
        end
        S_MULN: state <= S_DIVI;
        S_DIVI: state <= S_DIV;
        S_DIV: begin
          if (stat.div_last) begin
            state <= S_EMIT;
            sel   <= RES_PROBE_FP;
          end
        end
        S_EMIT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/brf_dp.sv
// Datapath of the bracketed root finder: bracket registers, config registers,
// shared multiplier, restoring divider and output register. Uses brf_pkg.
`default_nettype none
module brf_dp (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    cfg_we,
  input  wire  [brf_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire  [brf_pkg::TOL_WIDTH-1:0]          cfg_data,
  input  wire  [brf_pkg::IN_TDATA_W-1:0]         s_tdata,
  input  wire                                    s_tuser,
  output logic                                   m_tvalid,
  input  wire                                    m_tready,
  output logic [brf_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                   m_tuser,
  input  brf_pkg::dp_cmd_t                       cmd,
  output brf_pkg::dp_stat_t                      stat
);
  import brf_pkg::*;

  localparam int W = VALUE_WIDTH;

  logic                        method;
  logic [TOL_WIDTH-1:0]        tol;
  logic                        opc;
  logic signed [W-1:0]         pa, pb, va, vb, pv;
  logic signed [W-1:0]         low, high, lv, hv, last;
  logic                        searching;
  logic [PROD_WIDTH-1:0]       prod;
  logic [SPAN_WIDTH-1:0]       width_mag, den;
  logic                        neg;
  logic [PROD_WIDTH-1:0]       quo;
  logic [REM_WIDTH-1:0]        rem;
  logic [DIV_CNT_W-1:0]        cnt;
  logic                        out_done;
  logic signed [W-1:0]         out_point;
  logic [1:0]                  out_status;

  logic signed [SPAN_WIDTH-1:0] span, diff, sum;
  logic [SPAN_WIDTH-1:0]        span_mag, diff_mag;
  logic signed [W-1:0]          mid, fp_point, res_point;
  logic [MUL_WIDTH-1:0]         ma, mb;
  logic [2*MUL_WIDTH-1:0]       mp;
  logic [REM_WIDTH-1:0]         rem_sh, rem_sub;
  logic                         q_bit;
  logic [Q_WIDTH-1:0]           q;
  logic signed [C_WIDTH-1:0]    sq, c;
  logic                         res_done;
  logic [1:0]                   res_status;
  logic                         pv_pos;

  assign span     = SPAN_WIDTH'(high) - SPAN_WIDTH'(low);
  assign diff     = SPAN_WIDTH'(hv) - SPAN_WIDTH'(lv);
  assign sum      = SPAN_WIDTH'(low) + SPAN_WIDTH'(high);
  assign span_mag = span[SPAN_WIDTH-1] ? SPAN_WIDTH'(-span) : SPAN_WIDTH'(span);
  assign diff_mag = diff[SPAN_WIDTH-1] ? SPAN_WIDTH'(-diff) : SPAN_WIDTH'(diff);
  assign mid      = sum[SPAN_WIDTH-1:1];  // floor of the half sum
  assign pv_pos   = (pv != '0) && !pv[W-1];

  // one shared multiplier: tol*|low| for the relative stop, |hv|*|span| for the step
  always_comb begin
    if (cmd.op == DP_MUL_NUM) begin
      ma = MUL_WIDTH'(mag(hv));
      mb = span_mag;
    end else begin
      ma = MUL_WIDTH'(tol);
      mb = MUL_WIDTH'(mag(low));
    end
  end
  assign mp = ma * mb;

  assign rem_sh  = {rem[REM_WIDTH-2:0], quo[PROD_WIDTH-1]};
  assign q_bit   = (rem_sh >= REM_WIDTH'(den));
  assign rem_sub = rem_sh - REM_WIDTH'(den);

  always_comb begin
    if (den == '0)                       q = '0;
    else if (quo > PROD_WIDTH'(QCAP))    q = QCAP;
    else                                 q = quo[Q_WIDTH-1:0];
    sq = neg ? -C_WIDTH'(q) : C_WIDTH'(q);
    c  = C_WIDTH'(high) - sq;
    if (c > $signed(C_WIDTH'({1'b0, {(W-1){1'b1}}})))
      fp_point = {1'b0, {(W-1){1'b1}}};
    else if (c < -$signed(C_WIDTH'({1'b1, {(W-1){1'b0}}})))
      fp_point = {1'b1, {(W-1){1'b0}}};
    else
      fp_point = c[W-1:0];
  end

  always_comb begin
    res_done   = 1'b1;
    res_status = ST_FOUND;
    res_point  = '0;
    case (cmd.sel)
      RES_PROBE_MID: begin res_done = 1'b0; res_point = mid; end
      RES_PROBE_FP:  begin res_done = 1'b0; res_point = fp_point; end
      RES_DONE_LOW:  res_point = low;
      RES_DONE_HIGH: res_point = high;
      RES_DONE_LAST: res_point = last;
      RES_DONE_MID:  res_point = mid;
      RES_NO_SIGN:   res_status = ST_NO_SIGN;
      RES_NO_CONV:   res_status = ST_NO_CONV;
      RES_IDLE:      res_status = ST_IDLE;
      default:       res_status = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.is_start   = (opc == OP_START);
    stat.searching  = searching;
    stat.method     = method;
    stat.low_zero   = (va == '0);
    stat.high_zero  = (vb == '0);
    stat.same_sign  = sgn_eq(va, vb);
    stat.probe_zero = (pv == '0);
    stat.low_match  = sgn_eq(pv, lv);
    stat.high_match = sgn_eq(pv, hv);
    stat.keep       = (width_mag > SPAN_WIDTH'(tol)) &&
                      ((PROD_WIDTH'(width_mag) << FRACTION_BITS) > prod);
    stat.low_small  = (mag(lv) < W'(tol));
    stat.high_small = (mag(hv) < W'(tol));
    stat.div_last   = (cnt == '1);
    stat.out_free   = !m_tvalid || m_tready;
  end

  assign m_tuser = out_done;
  assign m_tdata = {{(OUT_TDATA_W-W-2){1'b0}}, out_status, out_point};

  always_ff @(posedge clk) begin
    if (rst) begin
      method    <= METHOD_BISECT;
      tol       <= TOL_WIDTH'(1);
      searching <= 1'b0;
      m_tvalid  <= 1'b0;
      low       <= '0;
      high      <= '0;
      lv        <= '0;
      hv        <= '0;
      last      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_METHOD) method <= cfg_data[0];
        if (cfg_index == CFG_TOL)    tol    <= cfg_data;
      end
      if (cmd.op == DP_RESULT)      m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (cmd.op)
        DP_UPDATE: begin
          if (opc == OP_START) begin
            low <= pa; high <= pb; lv <= va; hv <= vb;
            searching <= 1'b1;
          end else if (searching) begin
            if (method == METHOD_BISECT) begin
              if (sgn_eq(pv, lv)) begin
                low <= last; lv <= pv;
              end else if (sgn_eq(pv, hv)) begin
                high <= last; hv <= pv;
              end
            end else if (pv != '0) begin
              if (lv > hv) begin
                if (pv_pos) begin low <= last; lv <= pv; end
                else        begin high <= last; hv <= pv; end
              end else if (lv < hv) begin
                if (pv_pos) begin high <= last; hv <= pv; end
                else        begin low <= last; lv <= pv; end
              end
            end
          end
        end
        DP_RESULT: begin
          if (res_done) searching <= 1'b0;
          else          last      <= res_point;
        end
        default: ;
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        opc <= s_tuser;
        pa  <= s_tdata[W-1:0];
        pb  <= s_tdata[2*W-1:W];
        va  <= s_tdata[3*W-1:2*W];
        vb  <= s_tdata[4*W-1:3*W];
        pv  <= s_tdata[5*W-1:4*W];
      end
      DP_MUL_TOL: begin
        prod      <= mp[PROD_WIDTH-1:0];
        width_mag <= span_mag;
      end
      DP_MUL_NUM: begin
        prod <= mp[PROD_WIDTH-1:0];
        den  <= diff_mag;
        neg  <= hv[W-1] ^ span[SPAN_WIDTH-1] ^ diff[SPAN_WIDTH-1];
      end
      DP_DIV_INIT: begin
        quo <= prod;
        rem <= '0;
        cnt <= '0;
      end
      DP_DIV_STEP: begin
        rem <= q_bit ? rem_sub : rem_sh;
        quo <= {quo[PROD_WIDTH-2:0], q_bit};
        cnt <= cnt + DIV_CNT_W'(1);
      end
      DP_RESULT: begin
        out_done   <= res_done;
        out_point  <= res_point;
        out_status <= res_status;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/core/bracketed_root_finder_unit.sv
// Top level of the bracketed root finder: sequencer plus datapath.
// Depends on brf_pkg, brf_ctrl and brf_dp.
`default_nettype none
// A start beat (tuser 0) carries both bracket ends and their function values;
// every later beat (tuser 1) carries the function value at the last probe.
// Each input beat yields one output beat: tuser 0 is a probe point to
// evaluate, tuser 1 a final result with status. One item is in flight at a
// time. A bisection step runs from accept through update, multiply, stop
// test and load; an item settled by the first check goes from update
// straight to load. A false-position step adds the numerator multiply, the
// divider load and the 64-step restoring divider that forms the step
// quotient. s_tready returns the cycle after the result loads. The output
// register lets the next input be accepted while a result waits on
// m_tready; the following result stalls until that beat leaves. Config
// writes belong to idle time.
module bracketed_root_finder_unit (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_we,
  input  wire  [brf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [brf_pkg::TOL_WIDTH-1:0]        cfg_data,
  input  wire                                  s_tvalid,
  output logic                                 s_tready,
  // point_a, point_b, value_a, value_b, probe_value (low bits first)
  input  wire  [brf_pkg::IN_TDATA_W-1:0]       s_tdata,
  // opcode
  input  wire                                  s_tuser,
  output logic                                 m_tvalid,
  input  wire                                  m_tready,
  // point_out, status, zero pad (low bits first)
  output logic [brf_pkg::OUT_TDATA_W-1:0]      m_tdata,
  // done_res
  output logic                                 m_tuser
);
  import brf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  brf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  brf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

  // probe requests always carry status zero
  a_probe_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[VALUE_WIDTH+1:VALUE_WIDTH] == ST_FOUND)
    else $error("probe beat with nonzero status");

  // one item at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while busy");

  // a result is only loaded when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == DP_RESULT |-> (!m_tvalid || m_tready))
    else $error("result overwrote a pending beat");

endmodule
`default_nettype wire
